// ===== rtl/core/bmic_pkg.sv =====
// Shared types, constants and register addresses of the bank mapper core.
`default_nettype none
package bmic_pkg;

  localparam int MODE_W      = 2;
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int MAPPED_W    = 21;
  localparam int MASK_W      = 8;
  localparam int CNT_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int PRG_BANK_BITS_DEF = 8;
  localparam int CHR_BANK_BITS_DEF = 8;

  localparam int PRG_SLOTS = 4;
  localparam int CHR_SLOTS = 8;

  localparam logic [ADDR_W-1:0] REG_IRQ_ACK   = 16'h4501;
  localparam logic [ADDR_W-1:0] REG_CNT_LO    = 16'h4502;
  localparam logic [ADDR_W-1:0] REG_CNT_HI    = 16'h4503;
  localparam logic [ADDR_W-1:0] REG_PRG_FIRST = 16'h4504;
  localparam logic [ADDR_W-1:0] REG_PRG_LAST  = 16'h4507;
  localparam logic [ADDR_W-1:0] REG_CHR_FIRST = 16'h4510;
  localparam logic [ADDR_W-1:0] REG_CHR_LAST  = 16'h4517;

  localparam logic [DATA_W-1:0] PRG_RESET_0 = 8'h00;
  localparam logic [DATA_W-1:0] PRG_RESET_1 = 8'h01;
  localparam logic [DATA_W-1:0] PRG_RESET_2 = 8'hFE;
  localparam logic [DATA_W-1:0] PRG_RESET_3 = 8'hFF;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_MASK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_ROM  = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_PRG   = 2'd2,
    MODE_CHR   = 2'd3
  } bmic_mode_t;

  typedef struct packed {
    bmic_mode_t          mode;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   value;
  } bmic_item_t;

  typedef struct packed {
    logic irq_pending;
    logic irq_next;
  } bmic_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/bmic_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
`default_nettype none
interface bmic_in_if import bmic_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] value;

  modport source (output valid, output mode, output address, output value, input ready);
  modport sink (input valid, input mode, input address, input value, output ready);
endinterface

interface bmic_out_if import bmic_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                irq_line;
  logic [MAPPED_W-1:0] mapped_address;
  logic                target_is_ram;

  modport source (output valid, output irq_line, output mapped_address, output target_is_ram,
                  input ready);
  modport sink (input valid, input irq_line, input mapped_address, input target_is_ram,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bmic_state.sv =====
// Bank registers, IRQ counter and the register write decode.
`default_nettype none
module bmic_state import bmic_pkg::*; #(
  parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
  parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  bmic_item_t               item,
  output logic [PRG_BANK_BITS-1:0] prg_banks [PRG_SLOTS],
  output logic [CHR_BANK_BITS-1:0] chr_banks [CHR_SLOTS],
  output bmic_status_t             status
);

  logic [PRG_BANK_BITS-1:0] prg_banks_next [PRG_SLOTS];
  logic [CHR_BANK_BITS-1:0] chr_banks_next [CHR_SLOTS];
  logic [CNT_W-1:0]         tick_counter;
  logic [CNT_W-1:0]         tick_counter_next;
  logic                     count_enable;
  logic                     count_enable_next;
  logic                     irq_pending;
  logic                     irq_pending_next;

  always_comb begin
    prg_banks_next    = prg_banks;
    chr_banks_next    = chr_banks;
    tick_counter_next = tick_counter;
    count_enable_next = count_enable;
    irq_pending_next  = irq_pending;
    case (item.mode)
      MODE_WRITE: begin
        if (item.address == REG_IRQ_ACK) begin
          count_enable_next = 1'b0;
          irq_pending_next  = 1'b0;
        end else if (item.address == REG_CNT_LO) begin
          tick_counter_next = {tick_counter[CNT_W-1:DATA_W], item.value};
        end else if (item.address == REG_CNT_HI) begin
          count_enable_next = 1'b1;
          tick_counter_next = {item.value, tick_counter[DATA_W-1:0]};
        end else if (item.address inside {[REG_PRG_FIRST:REG_PRG_LAST]}) begin
          prg_banks_next[item.address[1:0]] = item.value[PRG_BANK_BITS-1:0];
        end else if (item.address inside {[REG_CHR_FIRST:REG_CHR_LAST]}) begin
          chr_banks_next[item.address[2:0]] = item.value[CHR_BANK_BITS-1:0];
        end
      end
      MODE_TICK: begin
        if (count_enable) begin
          // The incremented count reaching 0xFFFF wraps to zero and raises the IRQ.
          if (&tick_counter[CNT_W-1:1]) begin
            tick_counter_next = '0;
            irq_pending_next  = 1'b1;
          end else begin
            tick_counter_next = tick_counter + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks[0] <= PRG_RESET_0[PRG_BANK_BITS-1:0];
      prg_banks[1] <= PRG_RESET_1[PRG_BANK_BITS-1:0];
      prg_banks[2] <= PRG_RESET_2[PRG_BANK_BITS-1:0];
      prg_banks[3] <= PRG_RESET_3[PRG_BANK_BITS-1:0];
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_banks[i] <= '0;
      end
      tick_counter <= '0;
      count_enable <= 1'b0;
      irq_pending  <= 1'b0;
    end else if (step) begin
      prg_banks    <= prg_banks_next;
      chr_banks    <= chr_banks_next;
      tick_counter <= tick_counter_next;
      count_enable <= count_enable_next;
      irq_pending  <= irq_pending_next;
    end
  end

  assign status.irq_pending = irq_pending;
  assign status.irq_next    = irq_pending_next;

endmodule
`default_nettype wire

// ===== rtl/core/bmic_xlate.sv =====
// PRG and CHR address translation through the bank registers.
`default_nettype none
module bmic_xlate import bmic_pkg::*; #(
  parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
  parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
  input  bmic_item_t               item,
  input  logic [PRG_BANK_BITS-1:0] prg_banks [PRG_SLOTS],
  input  logic [CHR_BANK_BITS-1:0] chr_banks [CHR_SLOTS],
  input  logic [MASK_W-1:0]        prg_bank_mask,
  input  logic [MASK_W-1:0]        chr_bank_mask,
  input  logic                     chr_rom_present,
  output logic [MAPPED_W-1:0]      mapped_address,
  output logic                     target_is_ram
);

  logic [MASK_W-1:0] prg_bank;
  logic [MASK_W-1:0] chr_bank;

  assign prg_bank = MASK_W'(prg_banks[item.address[14:13]]) & prg_bank_mask;
  assign chr_bank = MASK_W'(chr_banks[item.address[12:10]]) & chr_bank_mask;

  always_comb begin
    mapped_address = '0;
    target_is_ram  = 1'b0;
    case (item.mode)
      MODE_PRG: begin
        if (item.address[15]) begin
          mapped_address = {prg_bank, item.address[12:0]};
        end
      end
      MODE_CHR: begin
        mapped_address = MAPPED_W'({chr_bank, item.address[9:0]});
        target_is_ram  = ~chr_rom_present;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/bank_mapper_with_irq_counter_core.sv =====
// Top level of the bank mapper with IRQ counter: channel registers and configuration.
//
//   Channel | Dir | Payload                                   | Handshake
//   cmd     | in  | mode, address, value                      | valid/ready
//   res     | out | irq_line, mapped_address, target_is_ram   | valid/ready
//   cfg     | in  | cfg_index, cfg_data                       | cfg_we
//
// One transaction per cycle is sustained while res.ready stays high; each command passes through
// the input register and then the result register; decode, bank lookup and the counter
// increment sit between them. Reset is synchronous. When a result is held, the input register
// keeps its transaction and cmd.ready drops.
`default_nettype none
module bank_mapper_with_irq_counter_core import bmic_pkg::*; #(
  parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
  parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  bmic_in_if.sink                cmd,
  bmic_out_if.source             res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                     s1_valid;
  bmic_item_t               s1_item;
  logic                     advance;
  logic                     out_valid;
  logic                     out_irq;
  logic [MAPPED_W-1:0]      out_mapped;
  logic                     out_ram;
  logic [MASK_W-1:0]        prg_bank_mask;
  logic [MASK_W-1:0]        chr_bank_mask;
  logic                     chr_rom_present;
  logic [PRG_BANK_BITS-1:0] prg_banks [PRG_SLOTS];
  logic [CHR_BANK_BITS-1:0] chr_banks [CHR_SLOTS];
  bmic_status_t             status;
  logic [MAPPED_W-1:0]      xl_mapped;
  logic                     xl_ram;

  assign advance   = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_mask   <= '1;
      chr_bank_mask   <= '1;
      chr_rom_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_MASK: prg_bank_mask   <= cfg_data[MASK_W-1:0];
        CFG_CHR_MASK: chr_bank_mask   <= cfg_data[MASK_W-1:0];
        CFG_CHR_ROM:  chr_rom_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_item.mode    <= bmic_mode_t'(cmd.mode);
      s1_item.address <= cmd.address;
      s1_item.value   <= cmd.value;
    end
  end

  bmic_state #(
    .PRG_BANK_BITS(PRG_BANK_BITS),
    .CHR_BANK_BITS(CHR_BANK_BITS)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (s1_item),
    .prg_banks (prg_banks),
    .chr_banks (chr_banks),
    .status    (status)
  );

  bmic_xlate #(
    .PRG_BANK_BITS(PRG_BANK_BITS),
    .CHR_BANK_BITS(CHR_BANK_BITS)
  ) u_xlate (
    .item            (s1_item),
    .prg_banks       (prg_banks),
    .chr_banks       (chr_banks),
    .prg_bank_mask   (prg_bank_mask),
    .chr_bank_mask   (chr_bank_mask),
    .chr_rom_present (chr_rom_present),
    .mapped_address  (xl_mapped),
    .target_is_ram   (xl_ram)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_irq    <= status.irq_next;
      out_mapped <= xl_mapped;
      out_ram    <= xl_ram;
    end
  end

  assign res.valid          = out_valid;
  assign res.irq_line       = out_irq;
  assign res.mapped_address = out_mapped;
  assign res.target_is_ram  = out_ram;

`ifndef SYNTHESIS
  a_irq_rise_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(status.irq_pending) |-> $past(advance && s1_item.mode == MODE_TICK))
    else $error("IRQ raised without an enabled tick");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("Input register lost a stalled transaction");

  a_ram_is_chr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ram |-> out_mapped[MAPPED_W-1:18] == '0)
    else $error("CHR RAM offset outside the CHR range");
`endif

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the bank mapper with IRQ counter core.
`default_nettype none
module testbench;
  import bmic_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam int END_SETTLE = 8;
  localparam logic [ADDR_W-1:0] PRG_WINDOW = 16'h8000;
  localparam logic [CNT_W:0] CNT_TOP = 17'h0FFFF;
  localparam logic [DATA_W-1:0] PRG_BITS = DATA_W'((1 << PRG_BANK_BITS_DEF) - 1);
  localparam logic [DATA_W-1:0] CHR_BITS = DATA_W'((1 << CHR_BANK_BITS_DEF) - 1);

  typedef struct packed {
    logic                irq;
    logic [MAPPED_W-1:0] mapped;
    logic                ram;
  } map_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmic_in_if cmd_if ();
  bmic_out_if res_if ();

  bank_mapper_with_irq_counter_core dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_if),
    .res      (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [DATA_W-1:0] prg_bank_reg [PRG_SLOTS];
  logic [DATA_W-1:0] chr_bank_reg [CHR_SLOTS];
  logic [CNT_W-1:0] irq_counter;
  logic counting;
  logic irq_flag;
  logic [MASK_W-1:0] prg_mask;
  logic [MASK_W-1:0] chr_mask;
  logic chr_is_rom;

  map_result_t expected_results[$];
  map_result_t oldest;
  int error_count = 0;
  int idle_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_request = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int rx_gap_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_mapper_model();
    prg_bank_reg[0] = PRG_RESET_0 & PRG_BITS;
    prg_bank_reg[1] = PRG_RESET_1 & PRG_BITS;
    prg_bank_reg[2] = PRG_RESET_2 & PRG_BITS;
    prg_bank_reg[3] = PRG_RESET_3 & PRG_BITS;
    for (int i = 0; i < CHR_SLOTS; i++) chr_bank_reg[i] = '0;
    irq_counter = '0;
    counting = 1'b0;
    irq_flag = 1'b0;
    prg_mask = '1;
    chr_mask = '1;
    chr_is_rom = 1'b1;
  endfunction

  function automatic map_result_t map_item(bmic_mode_t m, logic [ADDR_W-1:0] a,
                                           logic [DATA_W-1:0] v);
    logic [CNT_W:0] next_count;
    logic [DATA_W-1:0] bank;
    map_result_t r;
    r = '0;
    case (m)
      MODE_WRITE: begin
        if (a == REG_IRQ_ACK) begin
          counting = 1'b0;
          irq_flag = 1'b0;
        end else if (a == REG_CNT_LO) begin
          irq_counter[7:0] = v;
        end else if (a == REG_CNT_HI) begin
          counting = 1'b1;
          irq_counter[15:8] = v;
        end else if (a >= REG_PRG_FIRST && a <= REG_PRG_LAST) begin
          prg_bank_reg[a[1:0]] = v & PRG_BITS;
        end else if (a >= REG_CHR_FIRST && a <= REG_CHR_LAST) begin
          chr_bank_reg[a[2:0]] = v & CHR_BITS;
        end
      end
      MODE_TICK: begin
        if (counting) begin
          next_count = {1'b0, irq_counter} + 1'b1;
          if (next_count >= CNT_TOP) begin
            irq_counter = '0;
            irq_flag = 1'b1;
          end else begin
            irq_counter = next_count[CNT_W-1:0];
          end
        end
      end
      MODE_PRG: begin
        if (a >= PRG_WINDOW) begin
          bank = prg_bank_reg[a[14:13]] & prg_mask;
          r.mapped = {bank, a[12:0]};
        end
      end
      MODE_CHR: begin
        bank = chr_bank_reg[a[12:10]] & chr_mask;
        r.mapped = MAPPED_W'({bank, a[9:0]});
        r.ram = !chr_is_rom;
      end
      default: ;
    endcase
    r.irq = irq_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRG_MASK: prg_mask = cfg_data;
          CFG_CHR_MASK: chr_mask = cfg_data;
          CFG_CHR_ROM:  chr_is_rom = cfg_data[0];
          default: ;
        endcase
      end
      if (cmd_if.valid && cmd_if.ready)
        expected_results.push_back(map_item(bmic_mode_t'(cmd_if.mode), cmd_if.address,
                                            cmd_if.value));
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("Result transaction arrived with no expectation pending.");
          error_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (res_if.irq_line !== oldest.irq) begin
            $error("irq_line: expected %0d, actual %0d", oldest.irq, res_if.irq_line);
            error_count++;
          end
          if (res_if.mapped_address !== oldest.mapped) begin
            $error("mapped_address: expected 0x%06h, actual 0x%06h", oldest.mapped,
                   res_if.mapped_address);
            error_count++;
          end
          if (res_if.target_is_ram !== oldest.ram) begin
            $error("target_is_ram: expected %0d, actual %0d", oldest.ram,
                   res_if.target_is_ram);
            error_count++;
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left = 0;
      rx_gap_left = 0;
    end else if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = LONG_HOLD - 1;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      res_if.ready <= 1'b0;
    end else begin
      rx_gap_left = rx_idle_on ? pick_gap() : 0;
      res_if.ready <= (rx_gap_left == 0);
      if (rx_gap_left != 0) rx_gap_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(bmic_mode_t m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] v);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.mode <= m;
    cmd_if.address <= a;
    cmd_if.value <= v;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_item();
    int pick;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] v;
    pick = $urandom_range(0, 99);
    a = ADDR_W'($urandom);
    v = DATA_W'($urandom);
    if (pick < 12)
      send_item(MODE_WRITE, REG_PRG_FIRST + ADDR_W'($urandom_range(0, PRG_SLOTS - 1)), v);
    else if (pick < 22)
      send_item(MODE_WRITE, REG_CHR_FIRST + ADDR_W'($urandom_range(0, CHR_SLOTS - 1)), v);
    else if (pick < 28)
      send_item(MODE_WRITE, REG_IRQ_ACK + ADDR_W'($urandom_range(0, 2)), v);
    else if (pick < 33)
      send_item(MODE_WRITE, a, v);
    else if (pick < 50)
      send_item(MODE_TICK, a, v);
    else if (pick < 75)
      send_item(MODE_PRG, ($urandom_range(0, 4) == 0) ? a : (a | PRG_WINDOW), v);
    else
      send_item(MODE_CHR, a, v);
  endtask

  // Loads the counter close to its top, then mostly ticks so the IRQ fires.
  task automatic run_counter_sequence(output int sent);
    int length;
    send_item(MODE_WRITE, REG_CNT_LO, DATA_W'($urandom_range(8'hF0, 8'hFF)));
    send_item(MODE_WRITE, REG_CNT_HI, ($urandom_range(0, 9) == 0) ? DATA_W'($urandom) : 8'hFF);
    sent = 2;
    length = $urandom_range(4, 24);
    repeat (length) begin
      if ($urandom_range(0, 9) < 7) send_item(MODE_TICK, ADDR_W'($urandom), DATA_W'($urandom));
      else send_random_item();
      sent++;
    end
    if ($urandom_range(0, 2) == 0) begin
      send_item(MODE_WRITE, REG_IRQ_ACK, DATA_W'($urandom));
      sent++;
    end
  endtask

  task automatic run_traffic(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 3) begin
        run_counter_sequence(burst);
        sent += burst;
      end else begin
        send_random_item();
        sent++;
      end
    end
  endtask

  task automatic test_reset_mapping();
    send_item(MODE_PRG, 16'h8000, 8'h00);
    send_item(MODE_PRG, 16'hC000, 8'h00);
    send_item(MODE_PRG, 16'hFFFF, 8'hFF);
    send_item(MODE_PRG, 16'h7FFF, 8'h00);
    send_item(MODE_CHR, 16'h1FFF, 8'h00);
    send_item(MODE_TICK, 16'h0000, 8'h00);
  endtask

  task automatic test_bank_registers();
    send_item(MODE_WRITE, REG_PRG_FIRST, 8'hFF);
    send_item(MODE_WRITE, REG_PRG_LAST, 8'h00);
    send_item(MODE_WRITE, REG_CHR_FIRST, 8'hFF);
    send_item(MODE_WRITE, REG_CHR_LAST, 8'h55);
    send_item(MODE_WRITE, REG_IRQ_ACK - 1'b1, 8'hFF);
    send_item(MODE_WRITE, REG_PRG_LAST + 1'b1, 8'hFF);
    send_item(MODE_PRG, 16'h8000, 8'h00);
    send_item(MODE_PRG, 16'hFFFF, 8'h00);
    send_item(MODE_CHR, 16'hFFFF, 8'h00);
    send_item(MODE_CHR, 16'h0000, 8'h00);
  endtask

  task automatic test_irq_counter();
    send_item(MODE_WRITE, REG_CNT_LO, 8'hFD);
    send_item(MODE_WRITE, REG_CNT_HI, 8'hFF);
    send_item(MODE_TICK, 16'h0000, 8'h00);
    send_item(MODE_TICK, 16'hFFFF, 8'hFF);
    send_item(MODE_WRITE, REG_IRQ_ACK, 8'h00);
    send_item(MODE_WRITE, REG_CNT_LO, 8'hFF);
    send_item(MODE_WRITE, REG_CNT_HI, 8'hFF);
    send_item(MODE_TICK, 16'h0000, 8'h00);
    send_item(MODE_WRITE, REG_IRQ_ACK, 8'hFF);
  endtask

  task automatic test_config_sweep();
    logic [MASK_W-1:0] prg_settings [6];
    logic [MASK_W-1:0] chr_settings [6];
    logic rom_settings [6];
    prg_settings = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
    chr_settings = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
    rom_settings = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    for (int i = 4; i < 6; i++) begin
      prg_settings[i] = MASK_W'($urandom_range(0, 255));
      chr_settings[i] = MASK_W'($urandom_range(0, 255));
    end
    for (int i = 0; i < 6; i++) begin
      drain_results();
      write_register(CFG_PRG_MASK, prg_settings[i]);
      write_register(CFG_CHR_MASK, chr_settings[i]);
      write_register(CFG_CHR_ROM, CFG_DATA_W'(rom_settings[i]));
      run_traffic(50);
    end
  endtask

  task automatic test_result_backpressure();
    tx_idle_on = 1'b0;
    hold_request = ~hold_request;
    run_traffic(50);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    run_traffic(20);
    drain_results();
    run_traffic(20);
  endtask

  task automatic test_random_traffic();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_traffic(60);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_traffic(200);
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.mode = MODE_WRITE;
    cmd_if.address = '0;
    cmd_if.value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PRG_MASK;
    cfg_data = '0;
    reset_mapper_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_mapping();
    test_bank_registers();
    test_irq_counter();
    test_config_sweep();
    test_result_backpressure();
    test_sender_pause();
    test_random_traffic();
    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/bmic_pkg.sv
rtl/core/bmic_if.sv
rtl/core/bmic_state.sv
rtl/core/bmic_xlate.sv
rtl/core/bank_mapper_with_irq_counter_core.sv
verif/testbench.sv
